// ===== rtl/servo_slew_rate_controller_assert.svh =====
// ----------------------------------------------------------------------------
// Servo slew-rate controller assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SERVO_SLEW_RATE_CONTROLLER_ASSERT_SVH
`define SERVO_SLEW_RATE_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SRVSR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srvsr port check failed");

// Next-cycle implication, disabled while reset is high.
`define SRVSR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srvsr port check failed");

`endif

// ===== rtl/srvsr_pkg.sv =====
// ----------------------------------------------------------------------------
// Servo slew-rate controller package
// Beat types, settings bundle and fixed constants shared by the block.
// ----------------------------------------------------------------------------
package srvsr_pkg;

   // input beat: period tick or control message
   typedef struct packed {
      logic       cmd;
      logic [7:0] data_byte;
      logic [1:0] sender_code;
   } srvsr_req_type;

   // result beat: new angle and its PWM figures
   typedef struct packed {
      logic [7:0]  position_angle;
      logic [11:0] pulse_width_us;
      logic [3:0]  duty_percent;
   } srvsr_rsp_type;

   // commands and derived settings after a message
   typedef struct packed {
      logic [8:0]        angle_cmd;
      logic signed [9:0] delay_cmd;
      logic [7:0]        target;
      logic [3:0]        delay_ticks;
   } srvsr_settings_type;

   localparam logic             CMD_TICK    = 1'b0;
   localparam logic             CMD_MESSAGE = 1'b1;

   localparam logic [7:0]        MAX_ANGLE        = 8'd180;
   localparam logic [11:0]       PULSE_BASE_US    = 12'd500;
   localparam logic [7:0]        DELAY_PIVOT      = 8'd100;

   localparam logic [8:0]        ANGLE_CMD_RESET  = 9'd180;
   localparam logic signed [9:0] DELAY_CMD_RESET  = 10'sd100;
   localparam logic [7:0]        TARGET_RESET     = 8'd180;
   localparam logic [3:0]        TICKS_RESET      = 4'd5;

endpackage

// ===== rtl/srvsr_msg_decode.sv =====
// ----------------------------------------------------------------------------
// Servo slew-rate controller message decode
// Updates the angle or delay command from a message and derives target/ticks.
// ----------------------------------------------------------------------------
module srvsr_msg_decode
   import srvsr_pkg::*;
(
   input  logic [7:0]         data_byte,
   input  logic [1:0]         sender_code,
   input  logic [8:0]         angle_cmd,
   input  logic signed [9:0]  delay_cmd,
   output srvsr_settings_type settings
);

   logic [11:0]       scaled9;
   logic [25:0]       angle_prod;
   logic [8:0]        angle_new;
   logic              delay_neg;
   logic [7:0]        delay_mag;
   logic [9:0]        delay_five;
   logic [19:0]       delay_prod;
   logic [9:0]        delay_q;
   logic signed [9:0] delay_new;
   logic [5:0]        delay_quarter;
   logic [9:0]        ticks_prod;
   logic [8:0]        angle_sel;
   logic signed [9:0] delay_sel;
   logic [7:0]        target_sel;
   logic [3:0]        ticks_sel;

   // byte * 9 / 5, division by 5 as multiply by 3277 / 2^14
   assign scaled9    = {4'd0, data_byte} * 12'd9;
   assign angle_prod = {14'd0, scaled9} * 26'd3277;
   assign angle_new  = angle_prod[22:14];

   // 100 * (100 - byte) / 60 = 5 * |100 - byte| / 3, sign restored afterwards
   assign delay_neg  = data_byte > DELAY_PIVOT;
   assign delay_mag  = delay_neg ? (data_byte - DELAY_PIVOT) : (DELAY_PIVOT - data_byte);
   assign delay_five = {2'd0, delay_mag} * 10'd5;
   assign delay_prod = {10'd0, delay_five} * 20'd683;
   assign delay_q    = {1'b0, delay_prod[19:11]};
   assign delay_new  = delay_neg ? -$signed(delay_q) : $signed(delay_q);

   always_comb begin
      angle_sel = angle_cmd;
      delay_sel = delay_cmd;
      if (sender_code[0]) begin
         angle_sel = angle_new;
      end else if (sender_code[1]) begin
         delay_sel = delay_new;
      end
   end

   // clamp the target
   assign target_sel = (angle_sel > {1'b0, MAX_ANGLE}) ? MAX_ANGLE : angle_sel[7:0];

   // delay / 20 = (delay >> 2) / 5, the latter as multiply by 13 / 2^6
   assign delay_quarter = delay_sel[7:2];
   assign ticks_prod    = {4'd0, delay_quarter} * 10'd13;
   assign ticks_sel     = delay_sel[9] ? 4'd0 : ticks_prod[9:6];

   assign settings = {angle_sel, delay_sel, target_sel, ticks_sel};

endmodule

// ===== rtl/srvsr_pwm_calc.sv =====
// ----------------------------------------------------------------------------
// Servo slew-rate controller PWM calculation
// Turns an angle into the pulse width in microseconds and the duty percent.
// ----------------------------------------------------------------------------
module srvsr_pwm_calc
   import srvsr_pkg::*;
(
   input  logic [7:0]  angle,
   output logic [11:0] pulse_width_us,
   output logic [3:0]  duty_percent
);

   logic [28:0] span_prod;
   logic [11:0] span_us;

   // angle * 100 / 9 as multiply by 1456400 / 2^17, exact up to 180 degrees
   assign span_prod      = {21'd0, angle} * 29'd1456400;
   assign span_us        = span_prod[28:17];
   assign pulse_width_us = PULSE_BASE_US + span_us;

   // pulse / 200: count the hundreds-of-two thresholds passed above the floor
   always_comb begin
      duty_percent = 4'd2;
      for (int k = 3; k <= 12; k++) begin
         if (pulse_width_us >= 12'(k * 200)) begin
            duty_percent = duty_percent + 4'd1;
         end
      end
   end

endmodule

// ===== rtl/servo_slew_rate_controller.sv =====
// ----------------------------------------------------------------------------
// Servo slew-rate controller
// Ramps the servo angle one degree at a time toward the commanded target.
// ----------------------------------------------------------------------------
//
//   channel   ports                        direction  beat contents
//   -------   --------------------------   ---------  ------------------------------
//   request   req_valid req_stall req_data  in         tick or message (cmd/byte/code)
//   response  rsp_valid rsp_stall rsp_data  out        angle, pulse width, duty
//
// One beat a cycle is taken while the response side keeps up; each beat
// passes through the input register and leaves its result, if any, in
// the response register. The input register stalls only while a held
// response is itself stalled. Synchronous reset restores the command,
// target and tick state; there is no clearing pass and the block takes
// beats from the first cycle after reset.
//
module servo_slew_rate_controller
   import srvsr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  srvsr_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output srvsr_rsp_type rsp_data
);

   // input register
   logic              s1_valid_ff, s1_valid_in;
   srvsr_req_type     s1_item_ff;

   // controller state
   logic [8:0]        angle_cmd_ff, angle_cmd_in;
   logic signed [9:0] delay_cmd_ff, delay_cmd_in;
   logic [7:0]        current_ff, current_in;
   logic [7:0]        target_ff, target_in;
   logic [3:0]        ticks_ff, ticks_in;
   logic [3:0]        count_ff, count_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   srvsr_rsp_type     rsp_data_ff, rsp_data_in;

   srvsr_settings_type settings;
   logic              out_free;
   logic              advance;
   logic              moving;
   logic [3:0]        count_inc;
   logic              step;
   logic [7:0]        next_angle;
   logic [11:0]       pulse_width;
   logic [3:0]        duty;

   // the response register frees when empty or being taken this cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;

   srvsr_msg_decode u_decode (
      .data_byte   (s1_item_ff.data_byte),
      .sender_code (s1_item_ff.sender_code),
      .angle_cmd   (angle_cmd_ff),
      .delay_cmd   (delay_cmd_ff),
      .settings    (settings)
   );

   // tick path: count while off target, step once the count meets the delay
   assign moving     = current_ff != target_ff;
   assign count_inc  = count_ff + 4'd1;
   assign step       = moving && (count_inc >= ticks_ff);
   assign next_angle = (target_ff > current_ff) ? (current_ff + 8'd1) : (current_ff - 8'd1);

   srvsr_pwm_calc u_pwm (
      .angle          (next_angle),
      .pulse_width_us (pulse_width),
      .duty_percent   (duty)
   );

   always_comb begin
      angle_cmd_in = angle_cmd_ff;
      delay_cmd_in = delay_cmd_ff;
      current_in   = current_ff;
      target_in    = target_ff;
      ticks_in     = ticks_ff;
      count_in     = count_ff;
      if (advance) begin
         if (s1_item_ff.cmd == CMD_MESSAGE) begin
            // take the new commands, re-derive and restart the count
            angle_cmd_in = settings.angle_cmd;
            delay_cmd_in = settings.delay_cmd;
            target_in    = settings.target;
            ticks_in     = settings.delay_ticks;
            count_in     = 4'd0;
         end else if (moving) begin
            count_in = step ? 4'd0 : count_inc;
            if (step) begin
               current_in = next_angle;
            end
         end
      end
   end

   // load a result only when a tick steps the angle
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = advance && (s1_item_ff.cmd == CMD_TICK) && step;
         rsp_data_in.position_angle = next_angle;
         rsp_data_in.pulse_width_us = pulse_width;
         rsp_data_in.duty_percent   = duty;
      end
   end

   // take a new beat whenever the input register is empty or moving on
   assign s1_valid_in = req_stall ? s1_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         angle_cmd_ff <= ANGLE_CMD_RESET;
         delay_cmd_ff <= DELAY_CMD_RESET;
         current_ff   <= 8'd0;
         target_ff    <= TARGET_RESET;
         ticks_ff     <= TICKS_RESET;
         count_ff     <= 4'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_cmd_ff <= angle_cmd_in;
         delay_cmd_ff <= delay_cmd_in;
         current_ff   <= current_in;
         target_ff    <= target_in;
         ticks_ff     <= ticks_in;
         count_ff     <= count_in;
      end
   end

   // payload registers: hold while stalled, no reset needed
   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_item_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/srvsr_checker.sv =====
// ----------------------------------------------------------------------------
// Servo slew-rate controller port checker
// Watches the top-level ports over time; bound onto the controller.
// ----------------------------------------------------------------------------
`include "servo_slew_rate_controller_assert.svh"

module srvsr_checker
   import srvsr_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_stall,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input srvsr_rsp_type rsp_data
);

   // angle of the last delivered result; the ramp starts from zero
   logic [7:0] prev_angle_ff;
   logic       rsp_in_range;
   logic       rsp_one_step;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_angle_ff <= 8'd0;
      end else if (rsp_valid && !rsp_stall) begin
         prev_angle_ff <= rsp_data.position_angle;
      end
   end

   assign rsp_in_range = (rsp_data.position_angle <= MAX_ANGLE)
                      && (rsp_data.pulse_width_us >= PULSE_BASE_US)
                      && (rsp_data.pulse_width_us <= 12'd2500)
                      && (rsp_data.duty_percent >= 4'd2)
                      && (rsp_data.duty_percent <= 4'd12);

   assign rsp_one_step = (rsp_data.position_angle == prev_angle_ff + 8'd1)
                      || (rsp_data.position_angle == prev_angle_ff - 8'd1);

   `SRVSR_ASSERT_IMPL(a_no_stall_when_empty, clock, reset, !rsp_valid, !req_stall)
   `SRVSR_ASSERT_IMPL(a_result_range, clock, reset, rsp_valid, rsp_in_range)
   `SRVSR_ASSERT_IMPL(a_one_degree_step, clock, reset, rsp_valid && !rsp_stall, rsp_one_step)
   `SRVSR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

endmodule

bind servo_slew_rate_controller srvsr_checker u_srvsr_checker (.*);

// ===== sim/servo_slew_rate_controller_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo slew-rate controller testbench
// Drives period ticks and control messages into the block and checks every
// angle step against a cycle-free model of the ramp, with random idling and
// back-pressure on both channels.
// ----------------------------------------------------------------------------
module servo_slew_rate_controller_tb;
   import srvsr_pkg::*;

   // sender codes carried by a control message
   localparam logic [1:0] SENDER_NONE     = 2'b00;
   localparam logic [1:0] SENDER_POSITION = 2'b01;
   localparam logic [1:0] SENDER_SPEED    = 2'b10;
   localparam logic [1:0] SENDER_BOTH     = 2'b11;

   // idling styles for either channel
   localparam int IDLE_NONE  = 0;
   localparam int IDLE_LIGHT = 1;
   localparam int IDLE_HEAVY = 2;

   localparam int IDLE_LIMIT   = 2000;  // cycles with no beat on either side
   localparam int PIPE_SETTLE  = 4;     // settling margin after the last predicted step
   localparam int HOLDOFF_LONG = 150;

   logic          clock;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   srvsr_req_type req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   srvsr_rsp_type rsp_data;

   servo_slew_rate_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // ------------------------------------------------------------------------
   // Ramp model state
   // ------------------------------------------------------------------------
   logic [8:0]        cmd_angle;
   logic signed [9:0] cmd_delay_ms;
   logic [7:0]        servo_angle;
   logic [7:0]        goal_angle;
   logic [3:0]        ticks_per_degree;
   logic [3:0]        tick_total;

   srvsr_rsp_type pending_moves[$];   // steps predicted but not yet seen

   int req_idle_mode = IDLE_NONE;
   int rsp_idle_mode = IDLE_NONE;
   int holdoff_left  = 0;

   int mismatch_count   = 0;
   int beats_sent       = 0;
   int messages_sent    = 0;
   int moves_checked    = 0;
   int stalled_in_beats = 0;
   int lowest_angle     = 255;
   int highest_angle    = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Model of the ramp: apply one accepted beat, queue any step it causes
   // ------------------------------------------------------------------------
   task automatic reset_servo_model();
      cmd_angle        = ANGLE_CMD_RESET;
      cmd_delay_ms     = DELAY_CMD_RESET;
      servo_angle      = '0;
      goal_angle       = TARGET_RESET;
      ticks_per_degree = TICKS_RESET;
      tick_total       = '0;
   endtask

   task automatic step_servo_model(input srvsr_req_type beat);
      int            delay_ms;
      int            pulse;
      srvsr_rsp_type move;
      if (beat.cmd == CMD_MESSAGE) begin
         // position source wins over speed source
         if (beat.sender_code[0]) begin
            cmd_angle = 9'((int'(beat.data_byte) * 9) / 5);
         end else if (beat.sender_code[1]) begin
            cmd_delay_ms = 10'((100 * (int'(DELAY_PIVOT) - int'(beat.data_byte))) / 60);
         end
         // every message re-derives target and rate, and restarts the count
         goal_angle = (cmd_angle > 9'(MAX_ANGLE)) ? MAX_ANGLE : cmd_angle[7:0];
         delay_ms   = int'(cmd_delay_ms);
         ticks_per_degree = (delay_ms < 0) ? 4'd0 : 4'(delay_ms / 20);
         tick_total = '0;
      end else if (servo_angle != goal_angle) begin
         tick_total = tick_total + 4'd1;
         if (tick_total >= ticks_per_degree) begin
            servo_angle = (goal_angle > servo_angle) ? servo_angle + 8'd1
                                                     : servo_angle - 8'd1;
            tick_total  = '0;
            pulse = int'(PULSE_BASE_US) + (int'(servo_angle) * 2000) / int'(MAX_ANGLE);
            move.position_angle = servo_angle;
            move.pulse_width_us = 12'(pulse);
            move.duty_percent   = 4'((pulse * 100) / 20000);
            pending_moves.push_back(move);
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Idling: mostly short gaps, now and then a long one
   // ------------------------------------------------------------------------
   function automatic int pick_gap(input int mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (mode == IDLE_NONE) return 0;
      if (roll < ((mode == IDLE_LIGHT) ? 65 : 35)) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------
   // Offer one beat and hold it until the block takes it, then idle a while.
   // Valid stays high across back-to-back beats; it is only dropped for a gap.
   task automatic issue_beat(input logic cmd, input logic [7:0] data,
                             input logic [1:0] code);
      srvsr_req_type beat;
      int            gap;
      beat.cmd         = cmd;
      beat.data_byte   = data;
      beat.sender_code = code;
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (req_stall);
      step_servo_model(beat);
      beats_sent++;
      if (cmd == CMD_MESSAGE) messages_sent++;
      gap = pick_gap(req_idle_mode);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Ticks carry a payload the block ignores; randomise it anyway.
   task automatic issue_ticks(input int count);
      repeat (count) issue_beat(CMD_TICK, 8'($urandom_range(0, 255)),
                                2'($urandom_range(0, 3)));
   endtask

   // Drop valid and hold until every predicted step has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_moves.size() != 0) @(posedge clock);
      repeat (PIPE_SETTLE) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Receiver side: random stalls, plus a long hold-off on request
   // ------------------------------------------------------------------------
   initial begin : output_backpressure
      int stall_left;
      int run_left;
      stall_left = 0;
      run_left   = 0;
      forever begin
         @(posedge clock);
         if (holdoff_left > 0) begin
            rsp_stall <= 1'b1;
            holdoff_left--;
         end else begin
            if (stall_left == 0 && run_left == 0) begin
               stall_left = pick_gap(rsp_idle_mode);
               run_left   = $urandom_range(1, 8);
            end
            if (stall_left > 0) begin
               rsp_stall <= 1'b1;
               stall_left--;
            end else begin
               rsp_stall <= 1'b0;
               run_left--;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result checking
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : check_moves
      srvsr_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_moves.size() == 0) begin
            report_mismatch("unexpected step, angle", int'(rsp_data.position_angle), -1);
         end else begin
            want = pending_moves.pop_front();
            if (rsp_data.position_angle !== want.position_angle)
               report_mismatch("position_angle", int'(rsp_data.position_angle),
                               int'(want.position_angle));
            if (rsp_data.pulse_width_us !== want.pulse_width_us)
               report_mismatch("pulse_width_us", int'(rsp_data.pulse_width_us),
                               int'(want.pulse_width_us));
            if (rsp_data.duty_percent !== want.duty_percent)
               report_mismatch("duty_percent", int'(rsp_data.duty_percent),
                               int'(want.duty_percent));
         end
         moves_checked++;
         if (int'(rsp_data.position_angle) < lowest_angle)
            lowest_angle = int'(rsp_data.position_angle);
         if (int'(rsp_data.position_angle) > highest_angle)
            highest_angle = int'(rsp_data.position_angle);
      end
   end

   // Watchdog: give up if neither channel moves a beat for too long.
   always @(posedge clock) begin : watchdog
      int quiet_cycles;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (req_valid && req_stall) stalled_in_beats++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no beat accepted for %0d cycles", IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Walk the reset rate, every sender code, the field extremes, zero delay,
   // the longest delay and ticks that arrive with the servo already on target.
   task automatic test_directed_cases();
      req_idle_mode = IDLE_LIGHT;
      rsp_idle_mode = IDLE_LIGHT;
      issue_ticks(6);                                   // reset rate: 5 ticks a degree
      issue_beat(CMD_MESSAGE, 8'hFF, SENDER_NONE);      // nothing changes, count clears
      issue_beat(CMD_MESSAGE, 8'hFF, SENDER_SPEED);     // negative delay reads as zero
      issue_ticks(2);
      issue_beat(CMD_MESSAGE, 8'h00, SENDER_BOTH);      // position wins, angle 0
      issue_ticks(4);                                   // step down to 0, then idle tick
      issue_beat(CMD_MESSAGE, 8'hFF, SENDER_POSITION);  // 459 clamps to 180
      issue_beat(CMD_MESSAGE, 8'h00, SENDER_SPEED);     // longest delay, 8 ticks
      issue_ticks(9);
      issue_beat(CMD_MESSAGE, DELAY_PIVOT, SENDER_SPEED); // delay exactly zero
      issue_ticks(2);
      wait_drained();
   endtask

   // Hold the result channel off for a long stretch while ticks keep coming,
   // so the block fills and stalls its input; then drain.
   task automatic test_output_holdoff();
      req_idle_mode = IDLE_NONE;
      rsp_idle_mode = IDLE_NONE;
      issue_beat(CMD_MESSAGE, 8'hFF, SENDER_SPEED);
      issue_beat(CMD_MESSAGE, (servo_angle > 8'd90) ? 8'h00 : 8'hFF, SENDER_POSITION);
      holdoff_left = HOLDOFF_LONG;
      issue_ticks(30);
      wait_drained();
   endtask

   // Send a burst, pause the sender until every step has come out, resume.
   task automatic test_sender_drain_pause();
      req_idle_mode = IDLE_LIGHT;
      rsp_idle_mode = IDLE_HEAVY;
      issue_beat(CMD_MESSAGE, 8'd60, SENDER_SPEED);
      issue_ticks(20);
      wait_drained();
      issue_beat(CMD_MESSAGE, 8'($urandom_range(0, 255)), SENDER_POSITION);
      issue_ticks(20);
      wait_drained();
   endtask

   // Mostly ticks with a sprinkling of commands; position commands are often
   // aimed near the present angle so that ramps finish and settle on target.
   task automatic test_random_traffic(input int count);
      int         roll;
      int         pick;
      int         near;
      logic [7:0] data;
      logic [1:0] code;
      for (int n = 0; n < count; n++) begin
         if (n % 100 == 0) begin
            // first stretch runs flat out, the rest with random idling
            req_idle_mode = (n == 0) ? IDLE_NONE : $urandom_range(IDLE_NONE, IDLE_HEAVY);
            rsp_idle_mode = (n == 0) ? IDLE_NONE : $urandom_range(IDLE_NONE, IDLE_HEAVY);
         end
         roll = $urandom_range(0, 99);
         pick = $urandom_range(0, 3);
         if (roll < 5) begin
            code = $urandom_range(0, 1) ? SENDER_POSITION : SENDER_BOTH;
            near = (int'(servo_angle) * 5) / 9 + $urandom_range(0, 4);
            case (pick)
               0: data = 8'($urandom_range(0, 255));
               1: data = (near > 255) ? 8'hFF : 8'(near);
               2: data = 8'h00;
               default: data = 8'($urandom_range(100, 255));
            endcase
            issue_beat(CMD_MESSAGE, data, code);
         end else if (roll < 8) begin
            data = (pick == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(70, 255));
            issue_beat(CMD_MESSAGE, data, SENDER_SPEED);
         end else if (roll < 9) begin
            issue_beat(CMD_MESSAGE, 8'($urandom_range(0, 255)), SENDER_NONE);
         end else begin
            issue_ticks(1);
         end
      end
      wait_drained();
   endtask

   // ------------------------------------------------------------------------
   // Run
   // ------------------------------------------------------------------------
   initial begin
      reset_servo_model();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_output_holdoff();
      test_sender_drain_pause();
      test_random_traffic(900);

      $display("summary: %0d beats in (%0d commands), %0d angle steps checked",
               beats_sent, messages_sent, moves_checked);
      $display("summary: angles %0d..%0d reached, input held back on %0d cycles",
               lowest_angle, highest_angle, stalled_in_beats);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
